// ===== hdl/mrlq_pkg.sv =====
package mrlq_pkg;

   // sizing of the ring and of the resource bitmask
   localparam int RING_DEPTH    = 16;
   localparam int RESOURCE_BITS = 32;
   localparam int SLOT_W        = $clog2(RING_DEPTH);
   localparam int CNT_W         = $clog2(RING_DEPTH + 1);

   // fixed port widths
   localparam int OPCODE_W = 1;
   localparam int MASK_IN_W = 32;
   localparam int HANDLE_W = 4;
   localparam int KIND_W   = 3;

   // queue depths on both sides
   localparam int IN_DEPTH  = 2;
   localparam int IN_PTR_W  = $clog2(IN_DEPTH);
   localparam int IN_CNT_W  = $clog2(IN_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ZERO     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd4;
   localparam logic [KIND_W-1:0] KIND_BAD      = 3'd5;

   // classified request handed from front to back
   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic                     zero_mask;
      logic [RESOURCE_BITS-1:0] mask;
      logic [SLOT_W-1:0]        slot;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } result_type;

endpackage

// ===== hdl/mrlq_ram.sv =====
module mrlq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mrlq_front.sv =====
module mrlq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [mrlq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [mrlq_pkg::MASK_IN_W-1:0] req_resource_mask,
   input  logic [mrlq_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          item_valid,
   output mrlq_pkg::item_type            item,
   input  logic                          item_take
);
   import mrlq_pkg::*;

   item_type              buf_ff [IN_DEPTH];
   logic [IN_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IN_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IN_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type              cls;
   logic                  do_push;
   logic                  do_pop;

   // classify the incoming beat: effective mask, zero test, slot of handle
   always_comb begin
      cls.opcode    = req_opcode;
      cls.mask      = RESOURCE_BITS'(req_resource_mask);
      cls.zero_mask = (cls.mask == '0);
      cls.slot      = SLOT_W'(req_handle);
   end

   assign full       = (cnt_ff == IN_CNT_W'(IN_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = buf_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IN_PTR_W'(IN_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== hdl/mrlq_out_fifo.sv =====
module mrlq_out_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         res_push,
   input  mrlq_pkg::result_type         res_data,
   output logic                         res_full,
   output logic                         empty,
   input  logic                         pop,
   output logic [mrlq_pkg::KIND_W-1:0]   rsp_result_kind,
   output logic [mrlq_pkg::HANDLE_W-1:0] rsp_result_handle,
   output logic                         rsp_last_result
);
   import mrlq_pkg::*;

   result_type           buf_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;
   result_type           head;

   assign res_full = (cnt_ff == OUT_CNT_W'(OUT_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = res_push && !res_full;
   assign do_pop   = pop && !empty;

   assign head              = buf_ff[rd_ptr_ff];
   assign rsp_result_kind   = head.kind;
   assign rsp_result_handle = head.handle;
   assign rsp_last_result   = head.last;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wr_ptr_ff] <= res_data;
      end
   end

endmodule

// ===== hdl/mrlq_back.sv =====
module mrlq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  mrlq_pkg::item_type   item,
   output logic                 item_take,
   output logic                 res_push,
   output mrlq_pkg::result_type res_data,
   input  logic                 res_full
);
   import mrlq_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ACQ_G   = 3'd1;
   localparam logic [2:0] ST_POP     = 3'd2;
   localparam logic [2:0] ST_SCAN_RD = 3'd3;
   localparam logic [2:0] ST_SCAN_EV = 3'd4;
   localparam logic [2:0] ST_FIN     = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [SLOT_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [RING_DEPTH-1:0]    granted_ff, granted_in;
   logic [RING_DEPTH-1:0]    released_ff, released_in;
   logic [RESOURCE_BITS-1:0] union_ff, union_in;
   logic [RESOURCE_BITS-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [SLOT_W-1:0]        cur_ff, cur_in;
   logic                     pend_v_ff, pend_v_in;
   result_type               pend_ff, pend_in;

   logic                     ram_we;
   logic [SLOT_W-1:0]        ram_wa;
   logic [RESOURCE_BITS-1:0] ram_wd;
   logic [SLOT_W-1:0]        ram_ra;
   logic [RESOURCE_BITS-1:0] ram_rd;

   logic [SLOT_W-1:0]        tail;
   logic [SLOT_W-1:0]        scan_slot;
   logic [SLOT_W-1:0]        offset;
   logic                     grant_now;
   logic                     bad_rel;
   logic                     cand;

   // stored masks of the ring slots
   mrlq_ram #(
      .WIDTH(RESOURCE_BITS),
      .DEPTH(RING_DEPTH)
   ) u_masks (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   // slot arithmetic and checks
   assign tail      = head_ff + SLOT_W'(count_ff);
   assign scan_slot = head_ff + SLOT_W'(idx_ff);
   assign offset    = item.slot - head_ff;
   assign grant_now = ((union_ff & item.mask) == '0);
   assign bad_rel   = (CNT_W'(offset) >= count_ff) || released_ff[item.slot]
                      || !granted_ff[item.slot];
   assign cand      = !released_ff[scan_slot] && !granted_ff[scan_slot]
                      && ((ram_rd & acc_ff) == '0);

   // sequencer: one result at most per cycle, the previous one held back
   // until it is known whether it is the last of its item
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      granted_in  = granted_ff;
      released_in = released_ff;
      union_in    = union_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      item_take   = 1'b0;
      res_push    = 1'b0;
      res_data    = pend_ff;
      ram_we      = 1'b0;
      ram_wa      = tail;
      ram_wd      = item.mask;
      ram_ra      = scan_slot;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               pend_v_in = 1'b1;
               state_in  = ST_FIN;
               if (item.opcode == OP_ACQUIRE) begin
                  if (item.zero_mask) begin
                     pend_in = '{kind: KIND_ZERO, handle: '0, last: 1'b0};
                  end else if (count_ff == CNT_W'(RING_DEPTH)) begin
                     pend_in = '{kind: KIND_FULL, handle: '0, last: 1'b0};
                  end else begin
                     ram_we            = 1'b1;
                     released_in[tail] = 1'b0;
                     granted_in[tail]  = grant_now;
                     union_in          = union_ff | item.mask;
                     count_in          = count_ff + 1'b1;
                     cur_in            = tail;
                     pend_in = '{kind: KIND_QUEUED, handle: HANDLE_W'(tail), last: 1'b0};
                     if (grant_now) begin
                        state_in = ST_ACQ_G;
                     end
                  end
               end else begin
                  if (bad_rel) begin
                     pend_in = '{kind: KIND_BAD, handle: HANDLE_W'(item.slot), last: 1'b0};
                  end else begin
                     released_in[item.slot] = 1'b1;
                     pend_in  = '{kind: KIND_RELEASED, handle: HANDLE_W'(item.slot),
                                  last: 1'b0};
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_ACQ_G: begin
            if (!res_full) begin
               res_push = 1'b1;
               pend_in  = '{kind: KIND_GRANTED, handle: HANDLE_W'(cur_ff), last: 1'b0};
               state_in = ST_FIN;
            end
         end
         ST_POP: begin
            // retire released entries at the head, one a cycle
            if ((count_ff != '0) && released_ff[head_ff]) begin
               granted_in[head_ff] = 1'b0;
               head_in  = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end else begin
               idx_in   = '0;
               acc_in   = '0;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               union_in = acc_ff;
               state_in = ST_FIN;
            end else begin
               state_in = ST_SCAN_EV;
            end
         end
         ST_SCAN_EV: begin
            // grant a waiter whose mask misses all earlier live masks
            if (!cand || !res_full) begin
               if (!released_ff[scan_slot]) begin
                  acc_in = acc_ff | ram_rd;
               end
               if (cand) begin
                  granted_in[scan_slot] = 1'b1;
                  res_push = 1'b1;
                  pend_in  = '{kind: KIND_GRANTED, handle: HANDLE_W'(scan_slot),
                               last: 1'b0};
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_FIN: begin
            res_data.last = 1'b1;
            if (!res_full) begin
               res_push  = 1'b1;
               pend_v_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         count_ff    <= '0;
         granted_ff  <= '0;
         released_ff <= '0;
         union_ff    <= '0;
         pend_v_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         granted_ff  <= granted_in;
         released_ff <= released_in;
         union_ff    <= union_in;
         pend_v_ff   <= pend_v_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      idx_ff  <= idx_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("live entry count beyond ring depth");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_v_ff)
      else $error("held result left over in idle");

   a_fin_has_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> pend_v_ff)
      else $error("closing beat without a held result");

   a_grant_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_EV && cand) |-> (idx_ff < count_ff))
      else $error("grant outside the live entries");

endmodule

// ===== hdl/multi_resource_lock_queue_top.sv =====
// FIFO multi-resource lock on a ring of 16 slots. Push a request beat (acquire with a
// resource bitmask, or release of a granted handle); each request yields one or more
// result beats, the final one marked by rsp_last_result. Requests are processed one at
// a time. A good release first retires the released entries at the head of the ring,
// then the conflict unit scans the remaining live entries in order, each entry's mask
// read from the registered mask memory before it is checked; the entries retired and
// scanned together never exceed 16.
// A two-beat request queue and a four-beat result queue decouple both sides; a full
// result queue stalls the scan.
module multi_resource_lock_queue_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [mrlq_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [mrlq_pkg::MASK_IN_W-1:0] req_resource_mask,
   input  logic [mrlq_pkg::HANDLE_W-1:0]  req_handle,
   output logic                           empty,
   input  logic                           pop,
   output logic [mrlq_pkg::KIND_W-1:0]    rsp_result_kind,
   output logic [mrlq_pkg::HANDLE_W-1:0]  rsp_result_handle,
   output logic                           rsp_last_result
);
   import mrlq_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       res_push;
   result_type res_data;
   logic       res_full;

   // request queue and classification
   mrlq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_resource_mask(req_resource_mask),
      .req_handle       (req_handle),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   // lock state and conflict scan
   mrlq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item      (item),
      .item_take (item_take),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_full  (res_full)
   );

   // result queue
   mrlq_out_fifo u_out (
      .clock            (clock),
      .reset            (reset),
      .res_push         (res_push),
      .res_data         (res_data),
      .res_full         (res_full),
      .empty            (empty),
      .pop              (pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_handle(rsp_result_handle),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== tb/tb_multi_resource_lock_queue_top.sv =====
`timescale 1ns / 1ps

module tb_multi_resource_lock_queue_top;
   import mrlq_pkg::*;

   typedef struct {
      logic [OPCODE_W-1:0]  opcode;
      logic [MASK_IN_W-1:0] mask;
      logic [HANDLE_W-1:0]  handle;
   } lock_req_type;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } lock_rsp_type;

   localparam int CYCLE_LIMIT = 600000;

   logic                 clock;
   logic                 reset;
   logic                 push;
   logic                 full;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [MASK_IN_W-1:0] req_resource_mask;
   logic [HANDLE_W-1:0]  req_handle;
   logic                 empty;
   logic                 pop;
   logic [KIND_W-1:0]    rsp_result_kind;
   logic [HANDLE_W-1:0]  rsp_result_handle;
   logic                 rsp_last_result;

   multi_resource_lock_queue_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_opcode        (req_opcode),
      .req_resource_mask (req_resource_mask),
      .req_handle        (req_handle),
      .empty             (empty),
      .pop               (pop),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_result_handle (rsp_result_handle),
      .rsp_last_result   (rsp_last_result)
   );

   // lock state as the testbench sees it
   logic [RESOURCE_BITS-1:0] lock_mask [RING_DEPTH];
   bit                       lock_granted [RING_DEPTH];
   bit                       lock_written [RING_DEPTH];
   int                       lock_head;
   int                       lock_count;

   lock_req_type pending_reqs[$];
   lock_rsp_type expected_rsps[$];
   int        reqs_accepted = 0;
   int        reqs_issued = 0;
   int        rsps_checked = 0;
   int        grants_seen = 0;
   int        errors = 0;
   int        cycles = 0;
   bit        req_taken = 0;
   bit        hold_request = 0;
   int        hold_left = 0;
   int        push_gap = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int ring_slot(int offset);
      return (lock_head + offset) % RING_DEPTH;
   endfunction

   // no earlier live entry shares a resource with the one at offset
   function automatic bit entry_free(int offset);
      logic [RESOURCE_BITS-1:0] want;
      want = lock_mask[ring_slot(offset)];
      for (int i = 0; i < offset; i++)
         if ((lock_mask[ring_slot(i)] & want) != '0) return 0;
      return 1;
   endfunction

   function automatic void add_rsp(logic [KIND_W-1:0] kind, int slot);
      lock_rsp_type r;
      r.kind = kind;
      r.handle = slot[HANDLE_W-1:0];
      r.last = 1'b0;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   // apply one request to the lock state and queue its results
   function automatic void predict_lock(lock_req_type q);
      logic [RESOURCE_BITS-1:0] want;
      int slot, offset;
      want = q.mask[RESOURCE_BITS-1:0];
      if (q.opcode == OP_ACQUIRE) begin
         if (want == '0) begin
            add_rsp(KIND_ZERO, 0);
         end else if (lock_count >= RING_DEPTH) begin
            add_rsp(KIND_FULL, 0);
         end else begin
            slot = ring_slot(lock_count);
            lock_mask[slot] = want;
            lock_written[slot] = 1;
            lock_granted[slot] = 0;
            lock_count++;
            add_rsp(KIND_QUEUED, slot);
            if (entry_free(lock_count - 1)) begin
               lock_granted[slot] = 1;
               add_rsp(KIND_GRANTED, slot);
            end
         end
      end else begin
         slot = q.handle % RING_DEPTH;
         offset = (slot + RING_DEPTH - lock_head) % RING_DEPTH;
         if (offset >= lock_count || lock_mask[slot] == '0 || !lock_granted[slot]) begin
            add_rsp(KIND_BAD, slot);
         end else begin
            lock_mask[slot] = '0;
            add_rsp(KIND_RELEASED, slot);
            while (lock_count > 0 && lock_mask[lock_head] == '0) begin
               lock_granted[lock_head] = 0;
               lock_head = (lock_head + 1) % RING_DEPTH;
               lock_count--;
            end
            for (int i = 0; i < lock_count; i++) begin
               slot = ring_slot(i);
               if (!lock_granted[slot] && lock_mask[slot] != '0 && entry_free(i)) begin
                  lock_granted[slot] = 1;
                  add_rsp(KIND_GRANTED, slot);
               end
            end
         end
      end
      expected_rsps[expected_rsps.size() - 1].last = 1'b1;
   endfunction

   // request driver
   always @(negedge clock) begin
      logic                 nxt_push;
      logic [OPCODE_W-1:0]  nxt_op;
      logic [MASK_IN_W-1:0] nxt_mask;
      logic [HANDLE_W-1:0]  nxt_handle;
      lock_req_type         q;
      nxt_push = push;
      nxt_op = req_opcode;
      nxt_mask = req_resource_mask;
      nxt_handle = req_handle;
      if (!reset && !(push && !req_taken)) begin
         nxt_push = 1'b0;
         if (push_gap > 0) begin
            push_gap--;
         end else if (pending_reqs.size() > 0) begin
            q = pending_reqs.pop_front();
            nxt_push = 1'b1;
            nxt_op = q.opcode;
            nxt_mask = q.mask;
            nxt_handle = q.handle;
            push_gap = rand_gap();
         end
      end
      push <= nxt_push;
      req_opcode <= nxt_op;
      req_resource_mask <= nxt_mask;
      req_handle <= nxt_handle;
   end

   // result receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= !reset && (rand_gap() == 0);
      end
   end

   // accept requests and check result beats
   always @(posedge clock) begin
      lock_req_type q;
      lock_rsp_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_rsps.size());
         $display("tb: failure");
         $finish;
      end
      req_taken <= push && !full && !reset;
      if (!reset && push && !full) begin
         q.opcode = req_opcode;
         q.mask = req_resource_mask;
         q.handle = req_handle;
         predict_lock(q);
         reqs_accepted++;
      end
      if (!reset && pop && !empty) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected beat, actual kind=%0d handle=%0d last=%0d", $time,
                     rsp_result_kind, rsp_result_handle, rsp_last_result);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_result_kind !== e.kind) begin
               $display("%0t: kind mismatch, expected %0d actual %0d", $time, e.kind,
                        rsp_result_kind);
               errors++;
            end
            if (rsp_result_handle !== e.handle) begin
               $display("%0t: handle mismatch, expected %0d actual %0d", $time, e.handle,
                        rsp_result_handle);
               errors++;
            end
            if (rsp_last_result !== e.last) begin
               $display("%0t: last mismatch, expected %0d actual %0d", $time, e.last,
                        rsp_last_result);
               errors++;
            end
            if (e.kind == KIND_GRANTED) grants_seen++;
            rsps_checked++;
         end
      end
   end

   // hand one request to the driver and wait until it is taken
   task automatic issue(logic [OPCODE_W-1:0] op, logic [MASK_IN_W-1:0] mask,
                        logic [HANDLE_W-1:0] handle);
      lock_req_type q;
      q.opcode = op;
      q.mask = mask;
      q.handle = handle;
      pending_reqs.insert(pending_reqs.size(), q);
      reqs_issued++;
      while (reqs_accepted < reqs_issued) @(posedge clock);
   endtask

   task automatic drain();
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // well-formed traffic mostly: releases of granted handles, sparse acquires
   task automatic random_req();
      int granted_slots[$];
      int written_slots[$];
      int r;
      logic [MASK_IN_W-1:0] m;
      for (int s = 0; s < RING_DEPTH; s++) begin
         if (lock_written[s]) written_slots.insert(written_slots.size(), s);
         if (lock_granted[s] && lock_mask[s] != '0)
            granted_slots.insert(granted_slots.size(), s);
      end
      r = $urandom_range(0, 99);
      if (r < 45 && granted_slots.size() > 0) begin
         issue(OP_RELEASE, $urandom,
               HANDLE_W'(granted_slots[$urandom_range(0, granted_slots.size() - 1)]));
      end else if (r < 52 && written_slots.size() > 0) begin
         issue(OP_RELEASE, $urandom,
               HANDLE_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]));
      end else if (r < 56) begin
         issue(OP_ACQUIRE, '0, HANDLE_W'($urandom));
      end else if (r < 62) begin
         issue(OP_ACQUIRE, $urandom, HANDLE_W'($urandom));
      end else begin
         m = 32'd1 << $urandom_range(0, 5);
         if ($urandom_range(0, 2) == 0) m |= 32'd1 << $urandom_range(0, 31);
         issue(OP_ACQUIRE, m, HANDLE_W'($urandom));
      end
   endtask

   initial begin
      reset = 1'b1;
      clock = 1'b0;
      push = 1'b0;
      pop = 1'b0;
      req_opcode = OP_ACQUIRE;
      req_resource_mask = '0;
      req_handle = '0;
      lock_head = 0;
      lock_count = 0;
      for (int s = 0; s < RING_DEPTH; s++) begin
         lock_mask[s] = '0;
         lock_granted[s] = 0;
         lock_written[s] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero mask, waiting entry, bad releases, grant on release, full ring
      issue(OP_ACQUIRE, '0, 4'hF);
      issue(OP_ACQUIRE, 32'hFFFF_FFFF, 4'h0);
      issue(OP_ACQUIRE, 32'h0000_0001, 4'h0);
      issue(OP_RELEASE, '0, 4'd1);
      issue(OP_RELEASE, 32'hFFFF_FFFF, 4'd0);
      issue(OP_RELEASE, '0, 4'd0);
      issue(OP_ACQUIRE, 32'h8000_0000, 4'h0);
      for (int i = 0; i < 15; i++) issue(OP_ACQUIRE, 32'h0000_0001, 4'h0);
      issue(OP_RELEASE, '0, 4'd1);
      drain();

      // receiver holds off while requests keep coming
      hold_request = 1;
      for (int i = 0; i < 40; i++) random_req();
      drain();

      // random traffic, pausing for a full drain now and then
      for (int i = 0; i < 267; i++) begin
         random_req();
         if (i % 70 == 69) drain();
      end
      drain();
      repeat (100) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_rsps.size());
         errors++;
      end

      $display("run covered %0d requests, %0d result beats, %0d grants, %0d errors",
               reqs_accepted, rsps_checked, grants_seen, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
